@@ hw/rtl/ordered_array_list_defines.svh @@
// Assertion macros for the checker file of the ordered array list.
`ifndef ORDERED_ARRAY_LIST_DEFINES_SVH
`define ORDERED_ARRAY_LIST_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define OAL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ordered array list: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define OAL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ordered array list: next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define OAL_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("ordered array list: reset check failed");

`endif

@@ hw/rtl/oal_pkg.sv @@
// Shared types, codes and sizes of the ordered array list.
`default_nettype none
package oal_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths of the stream items.
    localparam int CMD_W  = 2;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int FIDX_W = 6;
    localparam int LEN_W  = 7;

    localparam int POS_LO      = CMD_W;
    localparam int VAL_LO      = POS_LO + POS_W;
    localparam int NVAL_LO     = VAL_LO + VAL_W;
    localparam int IN_W        = NVAL_LO + VAL_W;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int FIDX_LO     = STAT_W;
    localparam int LEN_LO      = FIDX_LO + FIDX_W;
    localparam int OUT_W       = LEN_LO + LEN_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // Width wide enough to compare a position against the count.
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // The match vector is encoded in groups of eight.
    localparam int GRP   = 8;
    localparam int GRP_W = 3;
    localparam int NGRP  = (CAPACITY + GRP - 1) / GRP;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT,
        CMD_DELETE,
        CMD_SEARCH,
        CMD_AMEND
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK,
        ST_BAD_POS,
        ST_FULL,
        ST_MISSING
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_ENC,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic load;
        logic cmp;
        logic enc;
        logic exec;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_stat;

endpackage
`default_nettype wire

@@ hw/rtl/ordered_array_list.sv @@
// Top level of the ordered array list: controller plus datapath.
//
// A positional list of up to CAPACITY signed 32-bit words. One command enters
// on the slave stream as a transaction; tdata carries command, position, value
// and new value. Each command yields exactly one result transaction on the
// master stream with status, found index and the list length afterwards.
// Commands: insert before a position, delete at a position, search for the
// first equal entry, and amend the first equal entry.
// Operands are captured when a command is accepted; then follow a parallel
// compare over all cells, a group encode and the update. The next command is
// taken in the cycle after the result is loaded, so commands are handled one
// at a time; this is set by the compare and two-level encode of the first-match
// search, which every command passes through.
// Reset clears the length count and the result register; cell contents are
// not cleared and are never read above the count.
// When the receiver stalls, the result is held in the output register and one
// more command may be accepted and processed up to its update, where it waits.
`default_nettype none
module ordered_array_list import oal_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // command[1:0], position[8:2], value[40:9], new_value[72:41], zero pad
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // status[1:0], found_index[7:2], list_length[14:8], zero pad
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    oal_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    oal_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_data   (i_s_axis_tdata),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule
`default_nettype wire

@@ hw/rtl/oal_ctrl.sv @@
// Control state machine that sequences one command through the datapath.
`default_nettype none
module oal_ctrl import oal_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = S_ENC;
            end
            S_ENC: begin
                o_cmd.enc = 1'b1;
                n_state   = S_EXEC;
            end
            S_EXEC: begin
                // The result register must be free before the list is updated.
                if (!i_stat.out_busy) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ hw/rtl/oal_dpath.sv @@
// Datapath: the row of list cells, the match search and the result register.
`default_nettype none
module oal_dpath import oal_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_dp_cmd                i_cmd,
    output t_dp_stat                    o_stat,
    input  wire logic [IN_TDATA_W-1:0]  i_in_data,
    input  wire logic                   i_out_ready,
    output logic                        o_out_valid,
    output logic [OUT_TDATA_W-1:0]      o_out_data
);

    t_cmd                     r_cmd;
    logic [POS_W-1:0]         r_pos;
    logic signed [VAL_W-1:0]  r_val;
    logic signed [VAL_W-1:0]  r_nval;
    logic signed [VAL_W-1:0]  r_cells [CAPACITY];
    logic [CNT_W-1:0]         r_count;
    logic [NGRP*GRP-1:0]      r_match;
    logic [NGRP*GRP-1:0]      n_match;
    logic [NGRP-1:0]          r_ghit;
    logic [NGRP-1:0]          n_ghit;
    logic [GRP_W-1:0]         r_gidx [NGRP];
    logic [GRP_W-1:0]         n_gidx [NGRP];
    logic                     r_out_valid;
    logic [OUT_TDATA_W-1:0]   r_out_data;

    logic                     w_hit;
    logic [IDX_W-1:0]         w_idx;
    t_status                  w_status;
    logic                     w_do_ins;
    logic                     w_do_del;
    logic                     w_do_amd;
    logic [CNT_W-1:0]         n_count;
    logic [FIDX_W-1:0]        w_fidx;
    logic [CMP_W-1:0]         w_pos_c;
    logic [CMP_W-1:0]         w_cnt_c;

    // Operand capture when a command is taken.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= t_cmd'(i_in_data[CMD_W-1:0]);
            r_pos  <= i_in_data[POS_LO +: POS_W];
            r_val  <= i_in_data[VAL_LO +: VAL_W];
            r_nval <= i_in_data[NVAL_LO +: VAL_W];
        end
    end

    // Every cell compares against the search value at once.
    always_comb begin
        n_match = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            n_match[i] = (r_cells[i] == r_val) && (CNT_W'(i) < r_count);
        end
    end

    // First hit inside each group of eight; lowest index wins.
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_ghit[g] = 1'b0;
            n_gidx[g] = '0;
            for (int k = GRP - 1; k >= 0; k--) begin
                if (r_match[g*GRP + k]) begin
                    n_ghit[g] = 1'b1;
                    n_gidx[g] = GRP_W'(k);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            r_match <= n_match;
        end
        if (i_cmd.enc) begin
            r_ghit <= n_ghit;
            r_gidx <= n_gidx;
        end
    end

    // First group with a hit gives the final index.
    always_comb begin
        w_hit = 1'b0;
        w_idx = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (r_ghit[g]) begin
                w_hit = 1'b1;
                w_idx = IDX_W'(g*GRP + int'(r_gidx[g]));
            end
        end
    end

    // Command decision; the position check comes before the full check.
    always_comb begin
        w_pos_c  = CMP_W'(r_pos);
        w_cnt_c  = CMP_W'(r_count);
        w_status = ST_OK;
        w_do_ins = 1'b0;
        w_do_del = 1'b0;
        w_do_amd = 1'b0;
        w_fidx   = '0;
        n_count  = r_count;
        case (r_cmd)
            CMD_INSERT: begin
                if (w_pos_c > w_cnt_c) begin
                    w_status = ST_BAD_POS;
                end else if (w_cnt_c >= CMP_W'(CAPACITY)) begin
                    w_status = ST_FULL;
                end else begin
                    w_do_ins = 1'b1;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            CMD_DELETE: begin
                if (w_pos_c >= w_cnt_c) begin
                    w_status = ST_BAD_POS;
                end else begin
                    w_do_del = 1'b1;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            default: begin
                if (!w_hit) begin
                    w_status = ST_MISSING;
                end else begin
                    w_fidx   = FIDX_W'(w_idx);
                    w_do_amd = (r_cmd == CMD_AMEND);
                end
            end
        endcase
    end

    // Each cell takes its own value, a neighbor, or a new operand.
    for (genvar c = 0; c < CAPACITY; c++) begin : g_cell
        localparam int LEFT  = (c == 0) ? 0 : c - 1;
        localparam int RIGHT = (c == CAPACITY - 1) ? c : c + 1;

        always_ff @(posedge i_clk) begin
            if (i_cmd.exec) begin
                if (w_do_ins) begin
                    if (CMP_W'(c) == w_pos_c) begin
                        r_cells[c] <= r_val;
                    end else if (CMP_W'(c) > w_pos_c) begin
                        r_cells[c] <= r_cells[LEFT];
                    end
                end else if (w_do_del) begin
                    if (CMP_W'(c) >= w_pos_c) begin
                        r_cells[c] <= r_cells[RIGHT];
                    end
                end else if (w_do_amd) begin
                    if (IDX_W'(c) == w_idx) begin
                        r_cells[c] <= r_nval;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    // Result register: holds a transaction until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_data <= OUT_TDATA_W'({LEN_W'(n_count), w_fidx, w_status});
        end
    end

    assign o_stat.out_busy = r_out_valid & ~i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out_data;

endmodule
`default_nettype wire

@@ hw/rtl/oal_checker.sv @@
// Port-level checker for the ordered array list, bound to the top level.
`default_nettype none
`include "ordered_array_list_defines.svh"
module oal_checker import oal_pkg::*; (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_s_axis_tvalid,
    input wire logic                   o_s_axis_tready,
    input wire logic                   o_m_axis_tvalid,
    input wire logic                   i_m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    logic             w_in_xact;
    logic             w_out_fail;
    logic             w_out_stall;
    logic [LEN_W-1:0] w_out_len;

    assign w_in_xact   = i_s_axis_tvalid & o_s_axis_tready;
    assign w_out_fail  = o_m_axis_tdata[STAT_W-1:0] != ST_OK;
    assign w_out_stall = o_m_axis_tvalid & ~i_m_axis_tready;
    assign w_out_len   = o_m_axis_tdata[LEN_LO +: LEN_W];

    // A stalled result stays put.
    `OAL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall, o_m_axis_tvalid && $stable(o_m_axis_tdata))

    // Commands are processed one at a time.
    `OAL_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, w_in_xact, !o_s_axis_tready)

    // The reported length never exceeds the store.
    `OAL_ASSERT_NOW(a_len_bound, i_clk, i_rst_n, o_m_axis_tvalid, w_out_len <= LEN_W'(CAPACITY))

    // A failed command reports index zero.
    `OAL_ASSERT_NOW(a_fail_idx, i_clk, i_rst_n, o_m_axis_tvalid && w_out_fail, o_m_axis_tdata[FIDX_LO +: FIDX_W] == '0)

    // Reset empties the result register.
    `OAL_ASSERT_ALWAYS(a_reset_out, i_clk, !i_rst_n, !o_m_axis_tvalid)

endmodule

bind ordered_array_list oal_checker u_oal_checker (.*);
`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking stream testbench for the ordered array list.
`timescale 1ns / 1ps

import oal_pkg::*;

typedef struct packed {
    t_status           status;
    logic [FIDX_W-1:0] found_index;
    logic [LEN_W-1:0]  list_length;
} list_reply_t;

class list_scoreboard;
    logic [VAL_W-1:0] cells [CAPACITY];
    int               length;
    list_reply_t      pending_replies [$];
    int               mismatches;

    function new();
        length     = 0;
        mismatches = 0;
    endfunction

    // Applies one accepted command to the shadow list and queues its reply.
    function void apply_command(t_cmd cmd, logic [POS_W-1:0] pos,
                                logic [VAL_W-1:0] val, logic [VAL_W-1:0] nval);
        list_reply_t reply;
        int          hit;
        reply.status      = ST_OK;
        reply.found_index = '0;
        hit               = -1;
        case (cmd)
            CMD_INSERT: begin
                // The position is checked before the fill level.
                if (pos > length) begin
                    reply.status = ST_BAD_POS;
                end else if (length >= CAPACITY) begin
                    reply.status = ST_FULL;
                end else begin
                    for (int i = length; i > pos; i--) cells[i] = cells[i-1];
                    cells[pos] = val;
                    length++;
                end
            end
            CMD_DELETE: begin
                if (pos >= length) begin
                    reply.status = ST_BAD_POS;
                end else begin
                    for (int i = pos + 1; i < length; i++) cells[i-1] = cells[i];
                    length--;
                end
            end
            default: begin
                for (int i = 0; i < length; i++) begin
                    if (hit < 0 && cells[i] == val) hit = i;
                end
                if (hit < 0) begin
                    reply.status = ST_MISSING;
                end else begin
                    reply.found_index = hit[FIDX_W-1:0];
                    if (cmd == CMD_AMEND) cells[hit] = nval;
                end
            end
        endcase
        reply.list_length = length[LEN_W-1:0];
        pending_replies.push_back(reply);
    endfunction

    task report_mismatch(string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task check_reply(logic [OUT_TDATA_W-1:0] data);
        list_reply_t want;
        t_status     got_status;
        logic [FIDX_W-1:0] got_index;
        logic [LEN_W-1:0]  got_length;
        got_status = t_status'(data[STAT_W-1:0]);
        got_index  = data[FIDX_LO +: FIDX_W];
        got_length = data[LEN_LO +: LEN_W];
        if (pending_replies.size() == 0) begin
            report_mismatch($sformatf("result %h arrived with no command pending", data));
        end else begin
            want = pending_replies.pop_front();
            if (got_status !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d",
                                          got_status, want.status));
            if (got_index !== want.found_index)
                report_mismatch($sformatf("found_index %0d, expected %0d",
                                          got_index, want.found_index));
            if (got_length !== want.list_length)
                report_mismatch($sformatf("list_length %0d, expected %0d",
                                          got_length, want.list_length));
        end
    endtask
endclass

module testbench;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    list_scoreboard sb;
    logic           quiet;

    ordered_array_list i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    task automatic send_command(input t_cmd cmd, input logic [POS_W-1:0] pos,
                                input logic [VAL_W-1:0] val,
                                input logic [VAL_W-1:0] nval);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 16);
        repeat (gap) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(IN_TDATA_W-IN_W){1'b0}}, nval, val, pos, cmd};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.apply_command(cmd, pos, val, nval);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            // A small pool of values keeps duplicates in the list.
            0: pick_value = VAL_W'($urandom_range(0, 7));
            1: begin
                case ($urandom_range(0, 2))
                    0:       pick_value = 32'h8000_0000;
                    1:       pick_value = 32'h7FFF_FFFF;
                    default: pick_value = 32'hFFFF_FFFF;
                endcase
            end
            default: pick_value = VAL_W'($urandom);
        endcase
    endfunction

    task automatic send_random(input int ins_pct, input int del_pct);
        int               roll;
        int               mode;
        t_cmd             cmd;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        logic [VAL_W-1:0] nval;
        roll = $urandom_range(0, 99);
        mode = $urandom_range(0, 9);
        if (roll < ins_pct)
            cmd = CMD_INSERT;
        else if (roll < ins_pct + del_pct)
            cmd = CMD_DELETE;
        else if ($urandom_range(0, 1))
            cmd = CMD_SEARCH;
        else
            cmd = CMD_AMEND;
        pos = POS_W'($urandom_range(0, 127));
        if (cmd == CMD_INSERT) begin
            if (mode < 7)
                pos = POS_W'($urandom_range(0, sb.length));
            else if (mode == 7)
                pos = POS_W'(sb.length);
            else if (mode == 8)
                pos = POS_W'(sb.length + 1);
        end else if (cmd == CMD_DELETE && sb.length > 0) begin
            if (mode < 7)
                pos = POS_W'($urandom_range(0, sb.length - 1));
            else if (mode == 7)
                pos = POS_W'(sb.length - 1);
            else if (mode == 8)
                pos = POS_W'(sb.length);
        end
        val  = pick_value();
        nval = pick_value();
        // Most lookups target a value that is actually held.
        if ((cmd == CMD_SEARCH || cmd == CMD_AMEND) && sb.length > 0 && mode < 7)
            val = sb.cells[$urandom_range(0, sb.length - 1)];
        send_command(cmd, pos, val, nval);
    endtask

    task automatic run_phase(input int items, input int ins_pct, input int del_pct,
                             input logic calm);
        quiet = calm;
        repeat (items) send_random(ins_pct, del_pct);
        quiet = 1'b0;
    endtask

    initial begin
        sb              = new();
        quiet           = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Operations on an empty list, including an insert past its end, then insertions at the front, middle and end.
        send_command(CMD_DELETE, 7'd0, 32'h0, 32'h0);
        send_command(CMD_SEARCH, 7'd0, 32'h0, 32'h0);
        send_command(CMD_AMEND,  7'd0, 32'h0, 32'h1);
        send_command(CMD_INSERT, 7'd1, 32'h5, 32'h0);
        send_command(CMD_INSERT, 7'd0, 32'h8000_0000, 32'h0);
        send_command(CMD_INSERT, 7'd1, 32'h7FFF_FFFF, 32'h0);
        send_command(CMD_INSERT, 7'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(CMD_INSERT, 7'd1, 32'h0000_0000, 32'h0);
        send_command(CMD_INSERT, 7'd4, 32'h7FFF_FFFF, 32'h0);
        // Duplicates: search and amend act on the first match only.
        send_command(CMD_SEARCH, 7'd0, 32'h7FFF_FFFF, 32'h0);
        send_command(CMD_AMEND,  7'd0, 32'h7FFF_FFFF, 32'h1234_5678);
        send_command(CMD_SEARCH, 7'd0, 32'h7FFF_FFFF, 32'h0);
        send_command(CMD_AMEND,  7'd0, 32'h0BAD_F00D, 32'hFFFF_FFFF);
        send_command(CMD_SEARCH, 7'd0, 32'h8000_0000, 32'h0);
        // Positions out of range, then deletes at the end and the front and a search for a deleted value.
        send_command(CMD_INSERT, 7'd127, 32'h1, 32'h0);
        send_command(CMD_INSERT, 7'd6,   32'h1, 32'h0);
        send_command(CMD_DELETE, 7'd127, 32'h0, 32'h0);
        send_command(CMD_DELETE, 7'd5,   32'h0, 32'h0);
        send_command(CMD_DELETE, 7'd4,   32'h0, 32'h0);
        send_command(CMD_DELETE, 7'd0,   32'h0, 32'h0);
        send_command(CMD_SEARCH, 7'd0,   32'hFFFF_FFFF, 32'h0);

        // Fill to capacity, churn, drain to empty, and again.
        run_phase(150, 90,  5, 1'b0);
        run_phase(100, 35, 30, 1'b1);
        run_phase(100, 10, 75, 1'b0);
        run_phase(150, 90,  5, 1'b1);
        run_phase(100, 30, 45, 1'b0);

        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending_replies.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        i_m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            repeat (quiet ? 0 : $urandom_range(0, 16)) begin
                @(negedge i_clk);
                i_m_axis_tready <= 1'b0;
            end
            @(negedge i_clk);
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid) @(posedge i_clk);
            sb.check_reply(o_m_axis_tdata);
        end
    end

    initial begin
        #1_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/oal_pkg.sv
hw/rtl/oal_ctrl.sv
hw/rtl/oal_dpath.sv
hw/rtl/ordered_array_list.sv
hw/rtl/oal_checker.sv
tb/testbench.sv
